FILE: hdl/rwhp_pkg.sv
// shared types and constants for the riff wave header parser
`default_nettype none
package rwhp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_CHDR,
        PH_FMT,
        PH_SKIP,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_WAVE = 2'd1,
        ST_MISSING  = 2'd2,
        ST_NOT_PCM  = 2'd3
    } hdr_status_t;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_PCM_LENGTH = 32'd18;
    localparam logic [15:0] FMT_PCM_TAG    = 16'd1;
    localparam logic [15:0] EIGHT_BITS     = 16'd8;
    localparam logic [32:0] RIFF_HDR_BYTES = 33'd12;

    typedef struct packed {
        hdr_status_t status;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] bits_per_sample;
        logic [31:0] data_offset;
        logic        unsigned_eight;
    } result_t;

endpackage
`default_nettype wire

FILE: hdl/rwhp_core.sv
// byte-wise chunk walker: parse state and the result of the current byte
`default_nettype none
module rwhp_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [7:0]       data_byte,
    input  wire logic             start_of_file,
    input  wire logic             end_of_buffer,
    output logic                  res_valid,
    output rwhp_pkg::result_t     res
);
    import rwhp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [4:0]  fc_reg, fc_next;
    logic [33:0] here_reg, here_next;
    logic        hbad_reg, hbad_next;
    logic        fseen_reg, fseen_next;
    logic [23:0] tag_reg, tag_next;
    logic [23:0] riff_reg, riff_next;
    logic [32:0] riff_end_reg, riff_end_next;
    logic [23:0] len_reg, len_next;
    logic [33:0] base_reg, base_next;
    logic        kind_fmt_reg, kind_fmt_next;
    logic        fmt_ok_reg, fmt_ok_next;
    logic [34:0] fmt_end_reg, fmt_end_next;
    logic [32:0] skip_reg, skip_next;
    logic [15:0] ftag_reg, ftag_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [7:0]  extra_lo_reg, extra_lo_next;

    phase_t      ph;
    logic [4:0]  fc;
    logic [33:0] here;
    logic        hbad;
    logic        fseen;
    logic [31:0] tag;
    logic [31:0] len_full;
    logic [34:0] len_sum;
    logic        gn_do;
    logic [34:0] gn_target;
    logic [34:0] gn_skip;
    logic        emit;
    hdr_status_t st;
    logic [31:0] off;
    logic        ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            fc_reg    <= '0;
            hbad_reg  <= 1'b0;
            fseen_reg <= 1'b0;
            here_reg  <= 34'd1;
        end else if (step) begin
            phase_reg <= phase_next;
            fc_reg    <= fc_next;
            hbad_reg  <= hbad_next;
            fseen_reg <= fseen_next;
            here_reg  <= here_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            tag_reg      <= tag_next;
            riff_reg     <= riff_next;
            riff_end_reg <= riff_end_next;
            len_reg      <= len_next;
            base_reg     <= base_next;
            kind_fmt_reg <= kind_fmt_next;
            fmt_ok_reg   <= fmt_ok_next;
            fmt_end_reg  <= fmt_end_next;
            skip_reg     <= skip_next;
            ftag_reg     <= ftag_next;
            chan_reg     <= chan_next;
            rate_reg     <= rate_next;
            bits_reg     <= bits_next;
            extra_lo_reg <= extra_lo_next;
        end
    end

    always_comb begin
        // a start of file restarts from any phase
        ph    = start_of_file ? PH_HDR : phase_reg;
        fc    = start_of_file ? 5'd0 : fc_reg;
        here  = start_of_file ? 34'd1 : here_reg;
        hbad  = start_of_file ? 1'b0 : hbad_reg;
        fseen = start_of_file ? 1'b0 : fseen_reg;

        tag      = {tag_reg, data_byte};
        len_full = {data_byte, len_reg};
        len_sum  = {1'b0, base_reg} + {3'd0, len_full};

        phase_next    = ph;
        fc_next       = fc;
        here_next     = here;
        hbad_next     = hbad;
        fseen_next    = fseen;
        tag_next      = tag_reg;
        riff_next     = riff_reg;
        riff_end_next = riff_end_reg;
        len_next      = len_reg;
        base_next     = base_reg;
        kind_fmt_next = kind_fmt_reg;
        fmt_ok_next   = fmt_ok_reg;
        fmt_end_next  = fmt_end_reg;
        skip_next     = skip_reg;
        ftag_next     = ftag_reg;
        chan_next     = chan_reg;
        rate_next     = rate_reg;
        bits_next     = bits_reg;
        extra_lo_next = extra_lo_reg;

        gn_do     = 1'b0;
        gn_target = '0;
        gn_skip   = '0;
        emit      = 1'b0;
        st        = ST_OK;
        off       = '0;

        if (ph != PH_IDLE && ph != PH_DONE) begin
            tag_next  = tag[23:0];
            here_next = here + 34'd1;
            fc_next   = fc + 5'd1;

            unique case (ph)
                PH_HDR: begin
                    if (fc == 5'd3 && tag != TAG_RIFF) hbad_next = 1'b1;
                    if (fc == 5'd4) riff_next[7:0]   = data_byte;
                    if (fc == 5'd5) riff_next[15:8]  = data_byte;
                    if (fc == 5'd6) riff_next[23:16] = data_byte;
                    if (fc == 5'd7) riff_end_next = {1'b0, data_byte, riff_reg} + 33'd8;
                    if (fc == 5'd11) begin
                        if (hbad || tag != TAG_WAVE) begin
                            emit = 1'b1;
                            st   = ST_NOT_WAVE;
                        end else if (riff_end_reg <= RIFF_HDR_BYTES) begin
                            emit = 1'b1;
                            st   = ST_MISSING;
                        end else begin
                            phase_next = PH_CHDR;
                            fc_next    = '0;
                            base_next  = 34'd20;
                        end
                    end
                end
                PH_CHDR: begin
                    if (fc == 5'd3 && tag == TAG_DATA) begin
                        emit = 1'b1;
                        off  = base_reg[31:0];
                        if (!fseen)          st = ST_MISSING;
                        else if (!fmt_ok_reg || ftag_reg != FMT_PCM_TAG) st = ST_NOT_PCM;
                        else                 st = ST_OK;
                    end else begin
                        if (fc == 5'd3) kind_fmt_next = (tag == TAG_FMT) && !fseen;
                        if (fc == 5'd4) len_next[7:0]   = data_byte;
                        if (fc == 5'd5) len_next[15:8]  = data_byte;
                        if (fc == 5'd6) len_next[23:16] = data_byte;
                        if (fc == 5'd7) begin
                            if (kind_fmt_reg) begin
                                fseen_next   = 1'b1;
                                fmt_ok_next  = (len_full == FMT_PCM_LENGTH);
                                fmt_end_next = len_sum;
                                phase_next   = PH_FMT;
                                fc_next      = '0;
                            end else begin
                                gn_do     = 1'b1;
                                gn_target = len_sum;
                            end
                        end
                    end
                end
                PH_FMT: begin
                    case (fc)
                        5'd0:  ftag_next[7:0]   = data_byte;
                        5'd1:  ftag_next[15:8]  = data_byte;
                        5'd2:  chan_next[7:0]   = data_byte;
                        5'd3:  chan_next[15:8]  = data_byte;
                        5'd4:  rate_next[7:0]   = data_byte;
                        5'd5:  rate_next[15:8]  = data_byte;
                        5'd6:  rate_next[23:16] = data_byte;
                        5'd7:  rate_next[31:24] = data_byte;
                        5'd14: bits_next[7:0]   = data_byte;
                        5'd15: bits_next[15:8]  = data_byte;
                        5'd16: extra_lo_next    = data_byte;
                        5'd17: begin
                            gn_do     = 1'b1;
                            gn_target = fmt_end_reg + {19'd0, data_byte, extra_lo_reg};
                        end
                        default: ;
                    endcase
                end
                PH_SKIP: begin
                    skip_next = skip_reg - 33'd1;
                    if (skip_next == '0) begin
                        phase_next = PH_CHDR;
                        fc_next    = '0;
                        base_next  = here + 34'd8;
                    end
                end
                default: ;
            endcase

            // move on to the next chunk, or stop at the riff end or when the next chunk lies behind this byte
            if (gn_do) begin
                gn_skip = gn_target - {1'b0, here};
                if (gn_target >= {2'd0, riff_end_reg}) begin
                    emit = 1'b1;
                    st   = ST_MISSING;
                end else if (gn_target < {1'b0, here}) begin
                    emit = 1'b1;
                    st   = ST_NOT_PCM;
                end else if (gn_skip == '0) begin
                    phase_next = PH_CHDR;
                    fc_next    = '0;
                    base_next  = gn_target[33:0] + 34'd8;
                end else begin
                    phase_next = PH_SKIP;
                    skip_next  = gn_skip[32:0];
                end
            end

            if (!emit && end_of_buffer) begin
                emit = 1'b1;
                st   = (phase_next == PH_HDR) ? ST_NOT_WAVE : ST_MISSING;
            end

            if (emit) phase_next = PH_DONE;
        end

        ok                  = (st == ST_OK);
        res_valid           = emit;
        res.status          = st;
        res.channel_count   = ok ? chan_reg : '0;
        res.sample_rate     = ok ? rate_reg : '0;
        res.bits_per_sample = ok ? bits_reg : '0;
        res.data_offset     = off;
        res.unsigned_eight  = ok && (bits_reg == EIGHT_BITS);
    end

endmodule
`default_nettype wire

FILE: hdl/riff_wave_header_parser_unit.sv
// top level of the riff wave header parser with the result register
//
// s_ channel: one file byte per beat. s_tdata carries the byte, s_tuser
// flags the first byte of a new file (restarts the parser from any point),
// s_tlast flags the last byte available in the buffer.
// m_ channel: at most one result per file, on the beat that carries the tag
// of the data chunk, or when the riff size or the buffer runs out, or on a
// bad header. The status says accepted, not riff wave, fmt or data missing,
// or fmt not pcm; format fields are zero unless accepted.
// result: registered, on m_ in the cycle after the byte that causes it.
// throughput: one byte per cycle while s_tready is high; each byte is one pass
// through the chunk walker between the parse state registers and the result register.
// bytes before a first start of file or after a result are dropped.
// reset: aresetn low waits for a start of file and drops any held result.
// stall: a held result still lets the next byte in when m_tready is high in
// the same cycle; otherwise s_tready drops until the result is taken.
`default_nettype none
module riff_wave_header_parser_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // data_byte
    input  wire logic         s_tlast,   // end_of_buffer
    input  wire logic [0:0]   s_tuser,   // start_of_file
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata    // status, channel_count, sample_rate,
                                         // bits_per_sample, data_offset,
                                         // unsigned_eight, zero pad
);
    import rwhp_pkg::*;

    logic    step;
    logic    res_valid;
    result_t res;
    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg, m_res_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    rwhp_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .data_byte     (s_tdata),
        .start_of_file (s_tuser[0]),
        .end_of_buffer (s_tlast),
        .res_valid     (res_valid),
        .res           (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_tready) m_valid_next = 1'b0;
        if (step && res_valid) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_res_reg.unsigned_eight, m_res_reg.data_offset,
                       m_res_reg.bits_per_sample, m_res_reg.sample_rate,
                       m_res_reg.channel_count, m_res_reg.status};

endmodule
`default_nettype wire

FILE: tb/riff_wave_header_parser_unit_tb.sv
// testbench for the riff wave header parser: directed and random wave files checked against a byte-level model
module riff_wave_header_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rwhp_pkg::*;

    localparam logic [31:0] TAG_FACT = 32'h6661_6374;
    localparam logic [31:0] TAG_JUNK = 32'h6A75_6E6B;

    typedef struct {
        hdr_status_t status;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [31:0] offset;
        logic        u8;
    } header_result_t;

    // models the chunk walker and keeps the results it should produce
    class header_parse_board;
        header_result_t expected_headers[$];
        int             failures;
        int             produced;

        phase_t      phase;
        logic [63:0] pos;
        logic [31:0] riff_len;
        logic [31:0] tag;
        logic [31:0] chunk_len;
        logic [63:0] skip;
        bit          fmt_seen;
        logic [31:0] fmt_len;
        logic [15:0] fmt_code;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [15:0] extra;
        int unsigned fcount;
        logic [63:0] cstart;
        bit          is_fmt;
        bit          hdr_bad;

        function new();
            failures = 0;
            produced = 0;
            clear();
        endfunction

        function void clear();
            phase = PH_IDLE;
            pos = '0; riff_len = '0; tag = '0; chunk_len = '0; skip = '0;
            fmt_seen = 0; fmt_len = '0; fmt_code = '0; chans = '0; rate = '0;
            bits = '0; extra = '0; fcount = 0; cstart = '0; is_fmt = 0; hdr_bad = 0;
        endfunction

        function int pending();
            return expected_headers.size();
        endfunction

        function bit emit_result(hdr_status_t st, logic [31:0] off);
            header_result_t r;
            bit ok;
            ok = (st == ST_OK);
            r.status = st;
            r.chans  = ok ? chans : 16'd0;
            r.rate   = ok ? rate : 32'd0;
            r.bits   = ok ? bits : 16'd0;
            r.offset = off;
            r.u8     = ok && (bits == EIGHT_BITS);
            expected_headers.push_back(r);
            produced++;
            phase = PH_DONE;
            return 1'b1;
        endfunction

        function void enter_chunk(logic [63:0] start);
            phase = PH_CHDR;
            fcount = 0;
            cstart = start;
            chunk_len = '0;
        endfunction

        function bit go_next(logic [63:0] next);
            logic [63:0] riff_end;
            logic [63:0] here;
            riff_end = {32'd0, riff_len} + 64'd8;
            here = pos + 64'd1;
            if (next >= riff_end)
                return emit_result(ST_MISSING, 32'd0);
            if (next < here)
                return emit_result(ST_NOT_PCM, 32'd0);
            skip = next - here;
            if (skip == 0)
                enter_chunk(next);
            else
                phase = PH_SKIP;
            return 1'b0;
        endfunction

        // returns 1 when the byte was taken by the parser, 0 when it is dropped
        function bit note_byte(logic [7:0] b, logic sof, logic eob);
            bit hit;
            int unsigned k;
            hdr_status_t st;
            hit = 0;
            if (sof) begin
                clear();
                phase = PH_HDR;
            end
            if (phase == PH_IDLE || phase == PH_DONE)
                return 1'b0;
            tag = {tag[23:0], b};
            k = fcount;
            case (phase)
                PH_HDR: begin
                    if (k == 3 && tag != TAG_RIFF)
                        hdr_bad = 1;
                    if (k >= 4 && k <= 7)
                        riff_len = riff_len | ({24'd0, b} << (8 * (k - 4)));
                    if (k == 11) begin
                        if (hdr_bad || tag != TAG_WAVE)
                            hit = emit_result(ST_NOT_WAVE, 32'd0);
                        else if (64'(RIFF_HDR_BYTES) >= {32'd0, riff_len} + 64'd8)
                            hit = emit_result(ST_MISSING, 32'd0);
                        else
                            enter_chunk(64'(RIFF_HDR_BYTES));
                    end else begin
                        fcount = k + 1;
                    end
                end
                PH_CHDR: begin
                    if (k == 3 && tag == TAG_DATA) begin
                        if (!fmt_seen)
                            st = ST_MISSING;
                        else if (fmt_len != FMT_PCM_LENGTH || fmt_code != FMT_PCM_TAG)
                            st = ST_NOT_PCM;
                        else
                            st = ST_OK;
                        hit = emit_result(st, cstart[31:0] + 32'd8);
                    end else begin
                        if (k == 3)
                            is_fmt = (tag == TAG_FMT) && !fmt_seen;
                        if (k >= 4 && k <= 7)
                            chunk_len = chunk_len | ({24'd0, b} << (8 * (k - 4)));
                        if (k == 7) begin
                            if (is_fmt) begin
                                fmt_seen = 1;
                                fmt_len = chunk_len;
                                phase = PH_FMT;
                                fcount = 0;
                            end else begin
                                hit = go_next(cstart + 64'd8 + {32'd0, chunk_len});
                            end
                        end else begin
                            fcount = k + 1;
                        end
                    end
                end
                PH_FMT: begin
                    case (k)
                        0: fmt_code = {8'd0, b};
                        1: fmt_code[15:8] = b;
                        2: chans = {8'd0, b};
                        3: chans[15:8] = b;
                        4, 5, 6, 7: rate = rate | ({24'd0, b} << (8 * (k - 4)));
                        14: bits = {8'd0, b};
                        15: bits[15:8] = b;
                        16: extra = {8'd0, b};
                        17: extra[15:8] = b;
                        default: ;
                    endcase
                    if (k == 17)
                        hit = go_next(cstart + 64'd8 + {32'd0, fmt_len} + {48'd0, extra});
                    else
                        fcount = k + 1;
                end
                PH_SKIP: begin
                    if (skip > 0)
                        skip = skip - 1;
                    if (skip == 0)
                        enter_chunk(pos + 64'd1);
                end
                default: ;
            endcase
            pos = pos + 64'd1;
            // buffer ran dry before a result
            if (!hit && eob && phase != PH_DONE)
                hit = emit_result(phase == PH_HDR ? ST_NOT_WAVE : ST_MISSING, 32'd0);
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                failures++;
                $display("%t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [103:0] beat);
            header_result_t r;
            if (expected_headers.size() == 0) begin
                failures++;
                $display("%t unexpected result: expected none, actual %h", $time, beat);
                return;
            end
            r = expected_headers.pop_front();
            compare_field("status", 64'(r.status), 64'(beat[1:0]));
            compare_field("channel_count", 64'(r.chans), 64'(beat[17:2]));
            compare_field("sample_rate", 64'(r.rate), 64'(beat[49:18]));
            compare_field("bits_per_sample", 64'(r.bits), 64'(beat[65:50]));
            compare_field("data_offset", 64'(r.offset), 64'(beat[97:66]));
            compare_field("unsigned_eight", 64'(r.u8), 64'(beat[98]));
            compare_field("pad", 64'd0, 64'(beat[103:99]));
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic         s_tlast = 1'b0;
    logic [0:0]   s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;

    header_parse_board board = new();
    logic [7:0]        file_bytes[$];
    int                src_idle = 38;
    int                sink_idle = 51;
    bit                hold_req = 1'b0;
    int                live_items = 0;

    riff_wave_header_parser_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic send_beat(logic [7:0] b, logic sof, logic eob);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(0, 99) < src_idle)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        s_tlast  <= eob;
        do @(posedge aclk); while (!s_tready);
        void'(board.note_byte(b, sof, eob));
        live_items++;
    endtask

    task automatic send_file(bit eob_end);
        for (int i = 0; i < file_bytes.size(); i++)
            send_beat(file_bytes[i], i == 0, eob_end && (i == file_bytes.size() - 1));
    endtask

    function automatic void put_tag(logic [31:0] t);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(t[8*i +: 8]);
    endfunction

    function automatic void put_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_noise(int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_header(logic [31:0] riff);
        file_bytes.delete();
        put_tag(TAG_RIFF);
        put_le(riff, 4);
        put_tag(TAG_WAVE);
    endfunction

    function automatic void set_riff(logic [31:0] v);
        for (int i = 0; i < 4; i++)
            file_bytes[4 + i] = v[8*i +: 8];
    endfunction

    function automatic void put_other_chunk(bit may_be_fmt);
        int n;
        int pick;
        logic [31:0] t;
        n = $urandom_range(0, 6);
        pick = $urandom_range(0, 2);
        t = (pick == 0) ? TAG_FACT : (pick == 1 && may_be_fmt) ? TAG_FMT : 32'($urandom);
        put_tag(t);
        put_le(n, 4);
        put_noise(n);
    endfunction

    function automatic void make_wave(logic [31:0] fmt_len, logic [15:0] code,
                                      logic [15:0] nch, logic [31:0] sps,
                                      logic [15:0] width, logic [15:0] ext,
                                      int n_pre, int n_post, int n_tail);
        longint pad;
        put_header(32'd0);
        repeat (n_pre) put_other_chunk(1'b0);
        put_tag(TAG_FMT);
        put_le(fmt_len, 4);
        put_le(32'(code), 2);
        put_le(32'(nch), 2);
        put_le(sps, 4);
        put_noise(6);
        put_le(32'(width), 2);
        put_le(32'(ext), 2);
        pad = longint'(fmt_len) + longint'(ext) - 18;
        if (pad > 0 && pad <= 64)
            put_noise(int'(pad));
        repeat (n_post) put_other_chunk(1'b1);
        put_tag(TAG_DATA);
        put_le($urandom, 4);
        put_noise(n_tail);
        set_riff(32'(file_bytes.size() - 8));
    endfunction

    function automatic void random_wave();
        logic [31:0] fl;
        logic [15:0] code;
        logic [15:0] nch;
        logic [15:0] width;
        logic [15:0] ext;
        int pick;
        fl = 32'd18;
        if ($urandom_range(0, 99) < 15) begin
            pick = $urandom_range(0, 3);
            fl = (pick == 0) ? 32'd16 : (pick == 1) ? 32'd20 : (pick == 2) ? 32'd2 : 32'd40;
        end
        code = ($urandom_range(0, 9) == 0) ? 16'($urandom) : FMT_PCM_TAG;
        nch = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 8)) : 16'($urandom);
        pick = $urandom_range(0, 4);
        width = (pick == 0) ? 16'd8 : (pick == 1) ? 16'd16 : (pick == 2) ? 16'd24 :
                (pick == 3) ? 16'd32 : 16'($urandom);
        ext = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 4)) : 16'd0;
        make_wave(fl, code, nch, $urandom, width, ext, $urandom_range(0, 2),
                  $urandom_range(0, 2), $urandom_range(0, 4));
    endfunction

    task automatic random_file();
        int kind;
        int cut;
        bit eob_end;
        kind = $urandom_range(0, 99);
        eob_end = 1'b0;
        random_wave();
        if (kind < 55) begin
            // well formed, content random
        end else if (kind < 63) begin
            put_header(32'h0000_1000);
            repeat ($urandom_range(0, 2)) put_other_chunk(1'b0);
            put_tag(TAG_DATA);
            put_noise($urandom_range(0, 4));
        end else if (kind < 71) begin
            cut = $urandom_range(0, 11);
            file_bytes[cut] = file_bytes[cut] ^ 8'($urandom_range(1, 255));
        end else if (kind < 79) begin
            set_riff($urandom_range(0, 48));
        end else if (kind < 89) begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut) void'(file_bytes.pop_back());
            eob_end = 1'b1;
        end else if (kind < 95) begin
            file_bytes.delete();
            put_noise($urandom_range(1, 24));
            eob_end = 1'($urandom_range(0, 1));
        end else begin
            // cut short, the next start of file restarts the parser
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
        if ($urandom_range(0, 9) == 0)
            eob_end = 1'b1;
        send_file(eob_end);
    endtask

    task automatic directed_files();
        // stray bytes before any start of file
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        make_wave(18, FMT_PCM_TAG, 16'hFFFF, 32'hFFFF_FFFF, EIGHT_BITS, 16'd0, 0, 0, 2);
        send_file(1'b0);
        make_wave(18, FMT_PCM_TAG, 16'd2, 32'd44100, 16'd16, 16'd0, 1, 1, 0);
        file_bytes[3] = 8'h58;
        send_file(1'b0);
        make_wave(18, FMT_PCM_TAG, 16'd2, 32'd44100, 16'd16, 16'd0, 0, 0, 0);
        file_bytes[11] = file_bytes[11] ^ 8'h01;
        send_file(1'b0);
        put_header(32'd0);
        send_file(1'b0);
        put_header(32'd100);
        while (file_bytes.size() > 6) void'(file_bytes.pop_back());
        send_file(1'b1);
        put_header(32'd100);
        send_file(1'b1);
        put_header(32'hFFFF_FFFF);
        put_tag(TAG_DATA);
        send_file(1'b0);
        put_header(32'hFFFF_FFFF);
        put_tag(TAG_JUNK);
        put_le(32'hFFFF_FFFF, 4);
        send_file(1'b0);
        make_wave(18, 16'hFFFF, 16'd0, 32'd0, 16'hFFFF, 16'd0, 0, 0, 0);
        send_file(1'b0);
        make_wave(2, FMT_PCM_TAG, 16'd1, 32'd8000, EIGHT_BITS, 16'd0, 0, 0, 0);
        send_file(1'b0);
        make_wave(18, FMT_PCM_TAG, 16'd1, 32'd8000, EIGHT_BITS, 16'hFFFF, 0, 0, 0);
        send_file(1'b0);
        make_wave(18, FMT_PCM_TAG, 16'd1, 32'd8000, 16'd16, 16'd0, 0, 0, 0);
        while (file_bytes.size() > 20) void'(file_bytes.pop_back());
        send_file(1'b0);
    endtask

    // result side: random stalls, plus one long hold-off at the start of each phase
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
            if (hold_req) begin
                hold_req = 1'b0;
                hold = 300;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_idle);
            end
        end
    end

    initial begin
        int drain;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_files();
        for (int ph = 0; ph < 3; ph++) begin
            src_idle  = (ph == 0) ? 38 : (ph == 1) ? 51 : 0;
            sink_idle = (ph == 0) ? 51 : (ph == 1) ? 38 : 0;
            hold_req = 1'b1;
            while (live_items < 600 * (ph + 1) || (ph == 2 && board.produced < 60))
                random_file();
        end
        s_tvalid <= 1'b0;
        drain = 0;
        while (board.pending() != 0 && drain < 5000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (10) @(posedge aclk);
        if (board.pending() != 0) begin
            board.failures++;
            $display("%t missing results: expected %0d more, actual none", $time,
                     board.pending());
        end
        if (board.failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
